// File: design/dfnr_pkg.sv
package dfnr_pkg;

  localparam int CHANNELS = 8;

  localparam logic [7:0] WIN_ALL_ONES  = 8'hFF;
  localparam logic [7:0] WIN_ALL_ZEROS = 8'h00;
  localparam logic [7:0] REPEAT_RESET  = 8'h01;

  localparam logic [1:0] REG_SKIP_ODD = 2'd0;
  localparam logic [1:0] REG_REPEAT   = 2'd1;
  localparam logic [1:0] REG_BASE     = 2'd2;

  typedef struct packed {
    logic [7:0] pin_levels;
    logic       tx_busy;
    logic       bus_active;
  } tick_t;

  typedef struct packed {
    logic [7:0] feedback_address;
    logic [4:0] nibble_word;
    logic       last;
  } nibble_t;

  // One command describes every word that a tick produces.
  typedef struct packed {
    logic          connect;
    logic          skip;
    logic [6:0]    base;
    logic [1:0]    group;
    logic [CHANNELS-1:0] pending;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic has_cmd;
  } qstat_t;

  function automatic logic [4:0] nibble_data(input cmd_t c, input logic [1:0] k);
    logic a;
    logic b;
    logic [4:0] w;
    a = c.pending[{k, 1'b0}];
    b = c.pending[{k, 1'b1}];
    if (c.skip) begin
      if (c.connect) begin
        w = {k[0], 2'b00, a, b};
      end else begin
        w = {k[0], a, b, a, b};
      end
    end else begin
      w = {k[0], c.pending[{k[0], 2'd2}], c.pending[{k[0], 2'd3}],
           c.pending[{k[0], 2'd0}], c.pending[{k[0], 2'd1}]};
    end
    return w;
  endfunction

  function automatic logic [7:0] nibble_addr(input cmd_t c, input logic [1:0] k);
    logic [7:0] a;
    a = {1'b0, c.base};
    if (c.skip) begin
      a = a + {7'd0, k[1]};
    end
    return a;
  endfunction

endpackage

// File: design/dfnr_front.sv
module dfnr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [7:0]          wr_data,
  input  logic                push,
  input  dfnr_pkg::tick_t     tick,
  input  dfnr_pkg::qstat_t    qstat,
  output logic                cmd_push,
  output dfnr_pkg::cmd_t      cmd,
  output logic                connected
);

  logic       skip_odd_mode;
  logic [7:0] repeat_count;
  logic [6:0] base_address;

  logic [7:0] win [dfnr_pkg::CHANNELS];
  logic [dfnr_pkg::CHANNELS-1:0] reported;
  logic [dfnr_pkg::CHANNELS-1:0] pending;
  logic [7:0] resend [dfnr_pkg::CHANNELS];

  logic [7:0] win_next [dfnr_pkg::CHANNELS];
  logic [7:0] res_s [dfnr_pkg::CHANNELS];
  logic [7:0] resend_next [dfnr_pkg::CHANNELS];
  logic [dfnr_pkg::CHANNELS-1:0] stab_s;
  logic [dfnr_pkg::CHANNELS-1:0] pend_s;
  logic [dfnr_pkg::CHANNELS-1:0] changed_s;
  logic [dfnr_pkg::CHANNELS-1:0] reported_next;
  logic [dfnr_pkg::CHANNELS-1:0] save_mask;
  logic [dfnr_pkg::CHANNELS-1:0] norm_mask;
  logic [1:0] hit4;
  logic [3:0] hit2;
  logic [1:0] norm_group;
  logic       norm_found;
  logic       emit_conn;
  logic       emit;
  logic       accept;
  logic       active;

  always_comb begin
    for (int i = 0; i < dfnr_pkg::CHANNELS; i++) begin
      win_next[i] = {win[i][6:0], tick.pin_levels[i]};
      stab_s[i] = (win_next[i] == dfnr_pkg::WIN_ALL_ONES) ||
                  (win_next[i] == dfnr_pkg::WIN_ALL_ZEROS);
      pend_s[i] = pending[i];
      res_s[i] = resend[i];
      if ((win_next[i] == dfnr_pkg::WIN_ALL_ZEROS && reported[i]) ||
          (win_next[i] == dfnr_pkg::WIN_ALL_ONES && !reported[i])) begin
        pend_s[i] = (win_next[i] == dfnr_pkg::WIN_ALL_ONES);
        res_s[i] = repeat_count;
      end
      changed_s[i] = (res_s[i] != 8'd0);
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      hit4[k] = (&stab_s[4*k +: 4]) && (|changed_s[4*k +: 4]);
    end
    for (int k = 0; k < 4; k++) begin
      hit2[k] = (&stab_s[2*k +: 2]) && (|changed_s[2*k +: 2]);
    end
  end

  // Lower groups win when several have something to send.
  always_comb begin
    norm_found = 1'b1;
    norm_group = 2'd0;
    norm_mask  = '0;
    if (skip_odd_mode) begin
      priority if (hit2[0]) begin
        norm_group = 2'd0;
        norm_mask  = 8'h03;
      end else if (hit2[1]) begin
        norm_group = 2'd1;
        norm_mask  = 8'h0C;
      end else if (hit2[2]) begin
        norm_group = 2'd2;
        norm_mask  = 8'h30;
      end else if (hit2[3]) begin
        norm_group = 2'd3;
        norm_mask  = 8'hC0;
      end else begin
        norm_found = 1'b0;
      end
    end else begin
      priority if (hit4[0]) begin
        norm_group = 2'd0;
        norm_mask  = 8'h0F;
      end else if (hit4[1]) begin
        norm_group = 2'd1;
        norm_mask  = 8'hF0;
      end else begin
        norm_found = 1'b0;
      end
    end
  end

  assign active    = (base_address != 7'd0);
  assign accept    = push && !qstat.full;
  assign emit_conn = !connected && tick.bus_active && (&stab_s);
  assign emit      = active && (connected ? (!tick.tx_busy && norm_found) : emit_conn);
  assign save_mask = emit ? (connected ? norm_mask : '1) : '0;
  assign cmd_push  = accept && emit;

  always_comb begin
    for (int i = 0; i < dfnr_pkg::CHANNELS; i++) begin
      reported_next[i] = save_mask[i] ? pend_s[i] : reported[i];
      resend_next[i]   = (save_mask[i] && res_s[i] != 8'd0) ? res_s[i] - 8'd1 : res_s[i];
    end
  end

  always_comb begin
    cmd.connect = !connected;
    cmd.skip    = skip_odd_mode;
    cmd.base    = base_address;
    cmd.group   = norm_group;
    cmd.pending = pend_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_odd_mode <= 1'b0;
      repeat_count  <= dfnr_pkg::REPEAT_RESET;
      base_address  <= 7'd0;
    end else if (wr_en) begin
      if (wr_index == dfnr_pkg::REG_SKIP_ODD) begin
        skip_odd_mode <= wr_data[0];
      end
      if (wr_index == dfnr_pkg::REG_REPEAT) begin
        repeat_count <= wr_data;
      end
      if (wr_index == dfnr_pkg::REG_BASE) begin
        base_address <= wr_data[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      connected <= 1'b0;
      reported  <= '0;
      pending   <= '0;
      for (int i = 0; i < dfnr_pkg::CHANNELS; i++) begin
        win[i]    <= 8'd0;
        resend[i] <= 8'd0;
      end
    end else if (accept && active) begin
      if (emit && !connected) begin
        connected <= 1'b1;
      end
      reported <= reported_next;
      pending  <= pend_s;
      for (int i = 0; i < dfnr_pkg::CHANNELS; i++) begin
        win[i]    <= win_next[i];
        resend[i] <= resend_next[i];
      end
    end
  end

endmodule

// File: design/dfnr_cmd_queue.sv
module dfnr_cmd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  dfnr_pkg::cmd_t    wr_cmd,
  input  logic              rd,
  output dfnr_pkg::cmd_t    head,
  output dfnr_pkg::qstat_t  qstat
);

  dfnr_pkg::cmd_t slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign head          = slots[rp];
  assign qstat.full    = (count == 2'd2);
  assign qstat.has_cmd = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wp] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wp <= ~wp;
      end
      if (rd) begin
        rp <= ~rp;
      end
      unique case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/dfnr_back.sv
module dfnr_back (
  input  logic              clk,
  input  logic              rst,
  input  dfnr_pkg::cmd_t    head,
  input  dfnr_pkg::qstat_t  qstat,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output dfnr_pkg::nibble_t nibble
);

  logic [1:0] idx;
  logic [1:0] k;
  logic       out_valid;
  logic       load;
  logic       last_word;

  // A connect run walks through all groups; a normal send is one word.
  assign k         = head.connect ? idx : head.group;
  assign last_word = !head.connect || (idx == (head.skip ? 2'd3 : 2'd1));
  assign load      = qstat.has_cmd && (!out_valid || pop);
  assign q_pop     = load && last_word;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      nibble.feedback_address <= dfnr_pkg::nibble_addr(head, k);
      nibble.nibble_word      <= dfnr_pkg::nibble_data(head, k);
      nibble.last             <= last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last_word ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: design/debounced_feedback_nibble_reporter_unit.sv
// A tick's command is written into the command queue; its first word is then registered at the result ports.
// Throughput: a tick is taken every cycle while the two-entry command queue has room.
// The word sequencer hands out one word per cycle while pop takes them; a connect run has two
// or four words, other sends one, so the sustained tick rate is set by the sequencer.
// Reset clears all channel state, the connect flag and the queues; repeat_count resets to one,
// skip_odd_mode and base_address to zero.
module debounced_feedback_nibble_reporter_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [1:0]        wr_index,
  input  logic [7:0]        wr_data,
  input  logic              push,
  output logic              full,
  input  dfnr_pkg::tick_t   tick,
  output logic              empty,
  input  logic              pop,
  output dfnr_pkg::nibble_t nibble
);

  dfnr_pkg::cmd_t   cmd;
  dfnr_pkg::cmd_t   head;
  dfnr_pkg::qstat_t qstat;
  logic             cmd_push;
  logic             q_pop;
  logic             connected;

  assign full = qstat.full;

  dfnr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .push      (push),
    .tick      (tick),
    .qstat     (qstat),
    .cmd_push  (cmd_push),
    .cmd       (cmd),
    .connected (connected)
  );

  dfnr_cmd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (cmd_push),
    .wr_cmd (cmd),
    .rd     (q_pop),
    .head   (head),
    .qstat  (qstat)
  );

  dfnr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .qstat  (qstat),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .nibble (nibble)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !qstat.full)
    else $error("command written into a full queue");

  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> !empty && nibble.last)
    else $error("command retired without its final word");

  a_run_pending: assert property (@(posedge clk) disable iff (rst)
    (!empty && !nibble.last) |-> qstat.has_cmd)
    else $error("unfinished run lost its command");

  a_stay_connected: assert property (@(posedge clk) disable iff (rst)
    connected |=> connected)
    else $error("link dropped out of connected state");
`endif

endmodule

// File: tb/debounced_feedback_nibble_reporter_unit_tb.sv
module debounced_feedback_nibble_reporter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dfnr_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_TICKS = 320;
  localparam int MIN_WORDS = 48;
  localparam int MAX_PHASES = 40;

  typedef enum logic [0:0] {ROW_TICK, ROW_CFG} row_kind_e;

  // A row either writes a register or offers a tick some number of times.
  // Rows flagged as typed carry their own expected words.
  typedef struct packed {
    row_kind_e        kind;
    logic [1:0]       reg_idx;
    logic [7:0]       reg_val;
    tick_t            tk;
    logic [7:0]       reps;
    logic             typed;
    logic [2:0]       n_words;
    nibble_t [0:3]    words;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    wr_en = 1'b0;
  logic [1:0] wr_index = '0;
  logic [7:0] wr_data = '0;
  logic    push = 1'b0;
  logic    full;
  tick_t   tick_drv = '0;
  logic    empty;
  logic    pop = 1'b0;
  nibble_t nibble_mon;

  // Shadow of the reporter: configuration and per-channel state.
  logic       cfg_skip;
  logic [7:0] cfg_repeat;
  logic [6:0] cfg_base;
  logic [7:0] win [CHANNELS];
  logic       reported [CHANNELS];
  logic       pend [CHANNELS];
  logic       stab [CHANNELS];
  logic [7:0] resend [CHANNELS];
  logic       linked;

  nibble_t tick_words[$];
  nibble_t nibbles_due[$];

  int mismatches = 0;
  int words_total = 0;
  int ticks_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;

  stim_row_t directed_rows [10] = '{
    // Address zero: the tick is dropped, nothing sampled.
    '{ROW_TICK, '0, '0, '{8'hFF, 1'b0, 1'b1}, 8'd1, 1'b1, 3'd0, '0},
    '{ROW_CFG, REG_SKIP_ODD, 8'd1, '0, 8'd1, 1'b0, 3'd0, '0},
    '{ROW_CFG, REG_BASE, 8'd127, '0, 8'd1, 1'b0, 3'd0, '0},
    // Bus inactive, so no connect run yet.
    '{ROW_TICK, '0, '0, '{8'h00, 1'b0, 1'b0}, 8'd1, 1'b1, 3'd0, '0},
    // Connect run in skip mode over base and base+1, sent despite tx_busy.
    '{ROW_TICK, '0, '0, '{8'h00, 1'b1, 1'b1}, 8'd1, 1'b1, 3'd4,
      '{'{8'd127, 5'h00, 1'b0}, '{8'd127, 5'h10, 1'b0},
        '{8'd128, 5'h00, 1'b0}, '{8'd128, 5'h10, 1'b1}}},
    '{ROW_TICK, '0, '0, '{8'hFF, 1'b0, 1'b1}, 8'd7, 1'b0, 3'd0, '0},
    // Every channel just went stable high, but the transmitter is busy.
    '{ROW_TICK, '0, '0, '{8'hFF, 1'b1, 1'b1}, 8'd1, 1'b1, 3'd0, '0},
    '{ROW_TICK, '0, '0, '{8'hFF, 1'b0, 1'b1}, 8'd4, 1'b0, 3'd0, '0},
    // A zero repeat count keeps changes from ever being sent.
    '{ROW_CFG, REG_REPEAT, 8'd0, '0, 8'd1, 1'b0, 3'd0, '0},
    '{ROW_TICK, '0, '0, '{8'h00, 1'b0, 1'b1}, 8'd8, 1'b0, 3'd0, '0}
  };

  debounced_feedback_nibble_reporter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .push     (push),
    .full     (full),
    .tick     (tick_drv),
    .empty    (empty),
    .pop      (pop),
    .nibble   (nibble_mon)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("debounced_feedback_nibble_reporter_unit_tb failed");
    $finish;
  end

  function automatic bit group_stable(input int c, input int g);
    bit ok;
    ok = 1'b1;
    for (int i = c; i < c + g; i++) begin
      if (!stab[i]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic void save_group(input int c, input int g);
    for (int i = c; i < c + g; i++) begin
      reported[i] = pend[i];
      if (resend[i] != 8'd0) resend[i] = resend[i] - 8'd1;
    end
  endfunction

  // Advances the shadow state by one tick and leaves its words in tick_words.
  function automatic void advance_reporter(input tick_t t);
    logic [7:0] w;
    logic [4:0] d;
    logic [7:0] a;
    int g;
    int c;
    bit sent;
    bit chg;
    nibble_t nb;
    tick_words.delete();
    if (cfg_base == 7'd0) return;
    for (int i = 0; i < CHANNELS; i++) begin
      w = {win[i][6:0], t.pin_levels[i]};
      win[i] = w;
      if (w == WIN_ALL_ZEROS || w == WIN_ALL_ONES) begin
        stab[i] = 1'b1;
        if (w == WIN_ALL_ZEROS && reported[i]) begin
          pend[i] = 1'b0;
          resend[i] = cfg_repeat;
        end
        if (w == WIN_ALL_ONES && !reported[i]) begin
          pend[i] = 1'b1;
          resend[i] = cfg_repeat;
        end
      end else begin
        stab[i] = 1'b0;
      end
    end
    if (!linked) begin
      if (t.bus_active && group_stable(0, CHANNELS)) begin
        g = cfg_skip ? 2 : 4;
        for (int k = 0; k < CHANNELS / g; k++) begin
          c = g * k;
          if (cfg_skip) begin
            d = {k[0], 2'b00, pend[c], pend[c + 1]};
            a = {1'b0, cfg_base} + 8'(k >> 1);
          end else begin
            d = {k[0], pend[c + 2], pend[c + 3], pend[c], pend[c + 1]};
            a = {1'b0, cfg_base};
          end
          tick_words.push_back('{a, d, 1'b0});
          save_group(c, g);
        end
        linked = 1'b1;
      end
    end else if (!t.tx_busy) begin
      g = cfg_skip ? 2 : 4;
      sent = 1'b0;
      for (int k = 0; k < CHANNELS / g && !sent; k++) begin
        c = g * k;
        chg = 1'b0;
        for (int i = c; i < c + g; i++) begin
          if (resend[i] != 8'd0) chg = 1'b1;
        end
        if (group_stable(c, g) && chg) begin
          if (cfg_skip) begin
            d = {k[0], pend[c], pend[c + 1], pend[c], pend[c + 1]};
            a = {1'b0, cfg_base} + 8'(k >> 1);
          end else begin
            d = {k[0], pend[c + 2], pend[c + 3], pend[c], pend[c + 1]};
            a = {1'b0, cfg_base};
          end
          tick_words.push_back('{a, d, 1'b0});
          save_group(c, g);
          sent = 1'b1;
        end
      end
    end
    if (tick_words.size() > 0) begin
      nb = tick_words[tick_words.size() - 1];
      nb.last = 1'b1;
      tick_words[tick_words.size() - 1] = nb;
    end
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    case (idx)
      REG_SKIP_ODD: cfg_skip = val[0];
      REG_REPEAT: cfg_repeat = val;
      REG_BASE: cfg_base = val[6:0];
      default: ;
    endcase
  endtask

  // Stops offering ticks until every expected word is back and the block has
  // had time to finish ticks that produce nothing.
  task automatic wait_idle();
    push <= 1'b0;
    while (nibbles_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_tick(input stim_row_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    tick_drv <= r.tk;
    @(posedge clk);
    while (full) @(posedge clk);
    advance_reporter(r.tk);
    if (r.typed) begin
      for (int i = 0; i < r.n_words; i++) nibbles_due.push_back(r.words[i]);
      words_total += r.n_words;
    end else begin
      foreach (tick_words[i]) nibbles_due.push_back(tick_words[i]);
      words_total += tick_words.size();
    end
  endtask

  // Result side: checks each taken word, then picks pop for the next edge.
  initial begin
    int hold_seen;
    int hold_left;
    nibble_t want;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (nibbles_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected word: addr %0d nibble %h last %b",
                     nibble_mon.feedback_address, nibble_mon.nibble_word, nibble_mon.last);
          end
        end else begin
          want = nibbles_due.pop_front();
          if (nibble_mon.feedback_address !== want.feedback_address ||
              nibble_mon.nibble_word !== want.nibble_word ||
              nibble_mon.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("word mismatch: expected addr %0d nibble %h last %b, got %0d %h %b",
                       want.feedback_address, want.nibble_word, want.last,
                       nibble_mon.feedback_address, nibble_mon.nibble_word,
                       nibble_mon.last);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    stim_row_t r;
    logic [7:0] lvl;
    logic [7:0] pins;
    logic [7:0] rep_val;
    logic [7:0] base_val;
    logic skip_val;
    int busy_pct;
    int n_ticks;
    int phase;
    cfg_skip = 1'b0;
    cfg_repeat = REPEAT_RESET;
    cfg_base = 7'd0;
    linked = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      win[i] = '0;
      reported[i] = 1'b0;
      pend[i] = 1'b0;
      stab[i] = 1'b0;
      resend[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    recv_stall_pct = 30;
    foreach (directed_rows[n]) begin
      if (directed_rows[n].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_rows[n].reg_idx, directed_rows[n].reg_val);
        wr_en <= 1'b0;
      end else begin
        for (int j = 0; j < directed_rows[n].reps; j++) send_tick(directed_rows[n]);
      end
    end

    lvl = 8'h00;
    phase = 0;
    while ((ticks_sent < RANDOM_TICKS || words_total < MIN_WORDS) && phase < MAX_PHASES) begin
      wait_idle();
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 59; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 59; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      skip_val = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0: rep_val = 8'd0;
        1: rep_val = 8'd1;
        2: rep_val = 8'd255;
        default: rep_val = 8'($urandom_range(2, 6));
      endcase
      case ($urandom_range(0, 3))
        0: base_val = 8'd1;
        1: base_val = 8'd127;
        default: base_val = 8'($urandom_range(2, 126));
      endcase
      busy_pct = 25;
      n_ticks = 40;
      if (phase == 0) begin
        // Long repeat count keeps words flowing while the receiver holds off.
        skip_val = 1'b0;
        rep_val = 8'd255;
        base_val = 8'd1;
        busy_pct = 5;
      end else if (phase == 1) begin
        skip_val = 1'b1;
        rep_val = 8'd1;
        base_val = 8'd127;
      end else if (phase == 2) begin
        base_val = 8'd0;
        n_ticks = 16;
      end
      write_reg(REG_SKIP_ODD, {7'd0, skip_val});
      write_reg(REG_REPEAT, rep_val);
      write_reg(REG_BASE, base_val);
      wr_en <= 1'b0;
      if (phase == 0) hold_req++;
      for (int j = 0; j < n_ticks; j++) begin
        // Mostly held levels with occasional flips and bounces, some pure noise.
        for (int ch = 0; ch < CHANNELS; ch++) begin
          if ($urandom_range(0, 15) == 0) lvl[ch] = ~lvl[ch];
        end
        pins = lvl;
        case ($urandom_range(0, 19))
          0: pins = 8'($urandom);
          1, 2: pins[$urandom_range(0, 7)] ^= 1'b1;
          default: ;
        endcase
        r = '0;
        r.kind = ROW_TICK;
        r.reps = 8'd1;
        r.tk.pin_levels = pins;
        r.tk.tx_busy = ($urandom_range(0, 99) < busy_pct);
        r.tk.bus_active = ($urandom_range(0, 19) != 0);
        send_tick(r);
        if (base_val != 8'd0) ticks_sent++;
      end
      phase++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("debounced_feedback_nibble_reporter_unit_tb passed");
    end else begin
      $display("debounced_feedback_nibble_reporter_unit_tb failed");
    end
    $finish;
  end

endmodule

// File: debounced_feedback_nibble_reporter_unit.f
design/dfnr_pkg.sv
design/dfnr_front.sv
design/dfnr_cmd_queue.sv
design/dfnr_back.sv
design/debounced_feedback_nibble_reporter_unit.sv
tb/debounced_feedback_nibble_reporter_unit_tb.sv
